### sv/chunked_body_decoder_unit_assert.svh
// Assertion macros shared by the decoder RTL.
// Synthesis sees empty bodies.
`ifndef CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define CBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/cbd_pkg.sv
`default_nettype none

package cbd_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        PH_LEAD = 3'd0,
        PH_SIZE = 3'd1,
        PH_DATA = 3'd2,
        PH_DCR  = 3'd3,
        PH_DLF  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2,
        ST_INC  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        t_status    status;
    } t_out_item;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        case (c) inside
            [8'h30:8'h39]: v = {1'b1, 4'(c - 8'h30)};
            [8'h41:8'h46]: v = {1'b1, 4'(c - 8'h37)};
            [8'h61:8'h66]: v = {1'b1, 4'(c - 8'h57)};
            default:       v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/chunked_body_decoder_unit.sv
// Chunked body decoder: strips HTTP chunked framing from a byte stream.
// Input channel: i_valid / o_stall / i_item carries one body byte and a
// flag marking the last byte in the buffer. An item transfers on a rising
// edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall / o_item gives exactly one result per
// input byte: a payload byte with body_valid, and a status (running, done,
// malformed, incomplete after chunk). A non-running status ends the body
// and the next byte starts a new one.
// Results are registered in the two-entry output buffer.
// Throughput: one byte per cycle while o_stall is low; the decode state
// registers update on every transfer, and a two-entry output buffer keeps
// input flowing while the receiver takes the current result.
// Stall: when the receiver stalls, the output result holds and the next
// result parks in the second entry; o_stall rises only while that entry is
// full.
// Reset (i_rst_n low, synchronous): decoder returns to the start of a size
// line and both output entries empty.
`default_nettype none

`include "chunked_body_decoder_unit_assert.svh"

module chunked_body_decoder_unit
    import cbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    logic      w_in_fire;
    logic      w_out_free;
    t_out_item w_result;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_skid, n_skid;

    assign o_stall    = r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;
    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    cbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_in_fire),
        .i_item   (i_item),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_out_free) begin
            if (r_skid_valid) begin
                // drain parked result first
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (w_in_fire) begin
                n_out_valid = 1'b1;
                n_out       = w_result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_in_fire) begin
            // hold output, park the new result
            n_skid_valid = 1'b1;
            n_skid       = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    `CBD_ASSERT(a_skid_order, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "parked result without output")
    `CBD_ASSERT(a_fire_shows, i_clk, i_rst_n, (w_in_fire && !r_out_valid) |=> r_out_valid, "transfer lost")
    `CBD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_skid_valid), "buffer not empty after reset")

endmodule

`default_nettype wire

### sv/cbd_core.sv
`default_nettype none

`include "chunked_body_decoder_unit_assert.svh"

module cbd_core
    import cbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_closed, n_closed;
    logic                 r_cr_pending, n_cr_pending;

    logic [7:0]           w_b;
    logic                 w_last;
    logic [4:0]           w_hex;
    logic                 w_lead;
    logic                 w_ovf;
    logic                 w_line_end;
    logic [SIZE_BITS-1:0] w_size_dec;

    assign w_b        = i_item.data_byte;
    assign w_last     = i_item.last_byte;
    assign w_hex      = f_hex(w_b);
    assign w_lead     = (r_phase != PH_SIZE);
    assign w_ovf      = |r_size[SIZE_BITS-1 -: 4];
    assign w_line_end = (w_b == CH_LF) && r_cr_pending;
    assign w_size_dec = r_size - SIZE_BITS'(1);

    // result of the current byte
    always_comb begin
        o_result.body_valid = 1'b0;
        o_result.body_byte  = 8'd0;
        o_result.status     = ST_RUN;
        case (r_phase)
            PH_DATA: begin
                o_result.body_valid = 1'b1;
                o_result.body_byte  = w_b;
                if (w_last) begin
                    o_result.status = ST_BAD;
                end
            end
            PH_DCR: begin
                if (w_b != CH_CR || w_last) begin
                    o_result.status = ST_BAD;
                end
            end
            PH_DLF: begin
                if (w_b != CH_LF) begin
                    o_result.status = ST_BAD;
                end else if (w_last) begin
                    o_result.status = ST_INC;
                end
            end
            default: begin
                if (w_line_end) begin
                    if (r_size == '0) begin
                        o_result.status = ST_DONE;
                    end else if (w_last) begin
                        o_result.status = ST_BAD;
                    end
                end else begin
                    if (!w_lead && !r_closed && w_hex[4] && w_ovf) begin
                        o_result.status = ST_BAD;
                    end else if (w_last) begin
                        o_result.status = ST_BAD;
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_size       = r_size;
        n_closed     = r_closed;
        n_cr_pending = r_cr_pending;
        case (r_phase)
            PH_DATA: begin
                n_size = w_size_dec;
                if (w_size_dec == '0) begin
                    n_phase = PH_DCR;
                end
            end
            PH_DCR: begin
                if (w_b == CH_CR && !w_last) begin
                    n_phase = PH_DLF;
                end
            end
            PH_DLF: begin
                n_phase      = PH_LEAD;
                n_size       = '0;
                n_closed     = 1'b0;
                n_cr_pending = 1'b0;
            end
            default: begin
                if (w_lead) begin
                    n_phase = PH_LEAD;
                end
                if (w_line_end) begin
                    n_phase      = PH_DATA;
                    n_closed     = 1'b0;
                    n_cr_pending = 1'b0;
                end else begin
                    n_cr_pending = (w_b == CH_CR);
                    if (w_lead) begin
                        if (w_hex[4]) begin
                            n_phase  = PH_SIZE;
                            n_size   = SIZE_BITS'(w_hex[3:0]);
                            n_closed = 1'b0;
                        end else if (w_b != CH_SP && w_b != CH_TAB) begin
                            n_phase  = PH_SIZE;
                            n_size   = '0;
                            n_closed = 1'b1;
                        end
                    end else if (!r_closed) begin
                        if (!w_hex[4]) begin
                            n_closed = 1'b1;
                        end else if (w_ovf) begin
                            n_size = '1;
                        end else begin
                            n_size = {r_size[SIZE_BITS-5:0], w_hex[3:0]};
                        end
                    end
                end
            end
        endcase
        // any end status starts a new body
        if (o_result.status != ST_RUN) begin
            n_phase      = PH_LEAD;
            n_size       = '0;
            n_closed     = 1'b0;
            n_cr_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_size       <= '0;
            r_closed     <= 1'b0;
            r_cr_pending <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_size       <= n_size;
            r_closed     <= n_closed;
            r_cr_pending <= n_cr_pending;
        end
    end

    `CBD_ASSERT(a_data_nonzero, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_size != '0), "data phase with zero count")
    `CBD_ASSERT(a_crlf_zero, i_clk, i_rst_n, (r_phase == PH_DCR || r_phase == PH_DLF) |-> (r_size == '0), "count left after data")
    `CBD_ASSERT(a_end_restart, i_clk, i_rst_n, (i_fire && o_result.status != ST_RUN) |=> (r_phase == PH_LEAD && r_size == '0 && !r_cr_pending), "no restart after end status")

endmodule

`default_nettype wire
